// ===== sv/srrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srrd_pkg
// Types and codes shared by the sprite row decoder: parse phases, span kinds,
// terminator codes, opcode boundaries and the result record.
// ----------------------------------------------------------------------------
package srrd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_OP    = 3'd2,
    PH_EXT   = 3'd3,
    PH_PAY   = 3'd4,
    PH_IDX   = 3'd5,
    PH_PAIR  = 3'd6,
    PH_DRAIN = 3'd7
  } phase_t;

  localparam logic [2:0] KIND_SKIP    = 3'd0;
  localparam logic [2:0] KIND_LITERAL = 3'd1;
  localparam logic [2:0] KIND_RECOLOR = 3'd2;
  localparam logic [2:0] KIND_ALPHA   = 3'd3;
  localparam logic [2:0] KIND_IDXA    = 3'd4;

  localparam logic [1:0] TERM_NONE   = 2'd0;
  localparam logic [1:0] TERM_ROW    = 2'd1;
  localparam logic [1:0] TERM_SPRITE = 2'd2;
  localparam logic [1:0] TERM_BAD    = 2'd3;

  localparam logic [7:0] OP_ROW_END    = 8'h00;
  localparam logic [7:0] OP_RECOLOR    = 8'h80;
  localparam logic [7:0] OP_ALPHA      = 8'ha0;
  localparam logic [7:0] OP_IDXA       = 8'hb0;
  localparam logic [7:0] OP_SPRITE_END = 8'hc0;
  localparam logic [7:0] HDR_MASK      = 8'h7f;
  localparam logic [7:0] SKIP_MASK     = 8'h3f;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] x;
    logic [7:0]  count;
    logic [7:0]  val_a;
    logic [7:0]  val_b;
    logic        row_end;
    logic [1:0]  term;
    logic [14:0] length;
    logic        bad;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/sprite_rle_row_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_rle_row_decoder
// Streaming parser for run-length coded sprite rows, one byte per cycle while in_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   in_byte / in_valid / in_stall carries the encoded row stream, header
//   first. A byte is taken at a clock edge with in_valid high and in_stall low.
//   out_* / out_valid / out_stall carries spans, pixels and end-of-row
//   results; a result moves when out_valid is high and out_stall is low.
//   cfg_data / cfg_valid / cfg_ready writes row_width; cfg_ready is always
//   high, so write it only while no byte or result is in flight.
// Throughput: one byte per cycle while in_stall is low; the parse update is combinational.
// Each result is registered in the output register, or in the skid register while the output stalls.
// Stall: the output register is backed by a skid register, so a byte is still
//   taken in the cycle the receiver first stalls; in_stall rises only when the
//   skid register holds a result, and drops once the output register drains.
// Reset (rst_n low, synchronous): no result pending, parser waits for a header
//   byte, row_width is 0 and all parse state is cleared.
// ----------------------------------------------------------------------------
module sprite_rle_row_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_span_kind,
  output logic [15:0]      out_span_x,
  output logic [7:0]       out_span_count,
  output logic [7:0]       out_value_a,
  output logic [7:0]       out_value_b,
  output logic             out_row_end,
  output logic [1:0]       out_row_term,
  output logic [14:0]      out_row_length,
  output logic             out_malformed,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import srrd_pkg::*;

  // configuration
  logic [15:0] row_width_r;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [14:0] bytes_left_r, bytes_left_nxt;
  logic [15:0] column_r, column_nxt;
  logic [2:0]  run_kind_r, run_kind_nxt;
  logic [7:0]  run_left_r, run_left_nxt;
  logic [1:0]  tint_r, tint_nxt;
  logic [7:0]  held_index_r, held_index_nxt;
  logic [6:0]  header_high_r, header_high_nxt;
  logic [1:0]  saved_term_r, saved_term_nxt;
  logic [14:0] row_len_r, row_len_nxt;

  // output and skid registers
  logic    out_valid_r, skid_valid_r;
  result_t out_r, skid_r;

  logic    in_accept, out_free;
  result_t res;
  logic    res_valid;

  // combinational parse signals
  logic [14:0] bl_dec;
  logic [7:0]  cnt_field;
  logic [7:0]  run_n;
  logic [2:0]  run_k;
  logic [2:0]  op_kind;
  logic [8:0]  need_n;
  logic [7:0]  width_n;
  logic        need_ok, width_ok;
  logic [16:0] width_sum;
  logic [14:0] hdr_len;
  logic        hdr_short;
  logic        do_emit, do_stop, end_row, bad;
  logic [1:0]  stop_code, term;
  logic [2:0]  emit_kind;
  logic [7:0]  emit_n, emit_a, emit_b;

  assign in_accept = in_valid & ~skid_valid_r;
  assign in_stall  = skid_valid_r;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    bl_dec    = bytes_left_r - 15'd1;
    cnt_field = (in_byte < OP_ALPHA) ? {5'd0, in_byte[2:0]} : {4'd0, in_byte[3:0]};
    if (in_byte < OP_ALPHA) begin
      op_kind = KIND_RECOLOR;
    end else if (in_byte < OP_IDXA) begin
      op_kind = KIND_ALPHA;
    end else begin
      op_kind = KIND_IDXA;
    end
    run_n = (phase_r == PH_EXT) ? in_byte : cnt_field;
    run_k = (phase_r == PH_EXT) ? run_kind_r : op_kind;

    // payload bytes still needed after this one
    if (phase_r == PH_OP && in_byte < OP_RECOLOR) begin
      need_n = {1'b0, in_byte};
    end else if (run_k == KIND_ALPHA) begin
      need_n = {1'b0, run_n};
    end else if (run_k == KIND_IDXA) begin
      need_n = {run_n, 1'b0};
    end else begin
      need_n = 9'd0;
    end

    if (phase_r == PH_EXT || in_byte < OP_RECOLOR) begin
      width_n = in_byte;
    end else if (in_byte < OP_SPRITE_END) begin
      width_n = cnt_field;
    end else begin
      width_n = in_byte & SKIP_MASK;
    end
    width_sum = {1'b0, column_r} + {9'd0, width_n};
    width_ok  = width_sum <= {1'b0, row_width_r};
    need_ok   = {6'd0, need_n} <= bl_dec;

    hdr_len   = (phase_r == PH_HDR0) ? {7'd0, in_byte} : {header_high_r, in_byte};
    hdr_short = (phase_r == PH_HDR0) ? (hdr_len == 15'd0) : (hdr_len < 15'd2);
  end

  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    column_nxt      = column_r;
    run_kind_nxt    = run_kind_r;
    run_left_nxt    = run_left_r;
    tint_nxt        = tint_r;
    held_index_nxt  = held_index_r;
    header_high_nxt = header_high_r;
    saved_term_nxt  = saved_term_r;
    row_len_nxt     = row_len_r;
    do_emit   = 1'b0;
    do_stop   = 1'b0;
    stop_code = TERM_BAD;
    emit_kind = KIND_SKIP;
    emit_n    = 8'd0;
    emit_a    = 8'd0;
    emit_b    = 8'd0;
    end_row   = 1'b0;
    bad       = 1'b0;
    term      = TERM_NONE;

    if (in_accept) begin
      if (phase_r == PH_HDR0 || phase_r == PH_HDR1) begin
        if (phase_r == PH_HDR0 && in_byte[7]) begin
          header_high_nxt = in_byte[6:0];
          phase_nxt       = PH_HDR1;
        end else begin
          row_len_nxt    = hdr_len;
          column_nxt     = 16'd0;
          saved_term_nxt = TERM_NONE;
          run_left_nxt   = 8'd0;
          if (hdr_short) begin
            end_row        = 1'b1;
            bad            = 1'b1;
            bytes_left_nxt = 15'd0;
            phase_nxt      = PH_HDR0;
          end else begin
            bytes_left_nxt = (phase_r == PH_HDR0) ? hdr_len - 15'd1 : hdr_len - 15'd2;
            if (bytes_left_nxt == 15'd0) begin
              end_row   = 1'b1;
              phase_nxt = PH_HDR0;
            end else begin
              phase_nxt = PH_OP;
            end
          end
        end
      end else begin
        bytes_left_nxt = bl_dec;
        unique case (phase_r)
          PH_OP: begin
            if (in_byte == OP_ROW_END) begin
              do_stop   = 1'b1;
              stop_code = TERM_ROW;
            end else if (in_byte == OP_SPRITE_END) begin
              do_stop   = 1'b1;
              stop_code = TERM_SPRITE;
            end else if (in_byte < OP_RECOLOR) begin
              run_kind_nxt = KIND_LITERAL;
              if (!need_ok || !width_ok) begin
                do_stop = 1'b1;
              end else begin
                run_left_nxt = in_byte;
                phase_nxt    = PH_PAY;
              end
            end else if (in_byte < OP_SPRITE_END) begin
              run_kind_nxt = op_kind;
              if (in_byte < OP_ALPHA) begin
                tint_nxt = in_byte[4:3];
              end
              if (cnt_field == 8'd0) begin
                // count follows in an extension byte
                if (bl_dec == 15'd0) begin
                  do_stop = 1'b1;
                end else begin
                  phase_nxt = PH_EXT;
                end
              end else if (!need_ok || !width_ok) begin
                do_stop = 1'b1;
              end else if (op_kind == KIND_RECOLOR) begin
                do_emit   = 1'b1;
                emit_kind = KIND_RECOLOR;
                emit_n    = cnt_field;
                emit_a    = {6'd0, tint_nxt};
              end else begin
                run_left_nxt = cnt_field;
                phase_nxt    = (op_kind == KIND_ALPHA) ? PH_PAY : PH_IDX;
              end
            end else begin
              if (!width_ok) begin
                do_stop = 1'b1;
              end else begin
                do_emit   = 1'b1;
                emit_kind = KIND_SKIP;
                emit_n    = in_byte & SKIP_MASK;
              end
            end
          end
          PH_EXT: begin
            if (!need_ok || !width_ok) begin
              do_stop = 1'b1;
            end else begin
              phase_nxt = PH_OP;
              if (run_n != 8'd0) begin
                if (run_k == KIND_RECOLOR) begin
                  do_emit   = 1'b1;
                  emit_kind = KIND_RECOLOR;
                  emit_n    = run_n;
                  emit_a    = {6'd0, tint_r};
                end else begin
                  run_left_nxt = run_n;
                  phase_nxt    = (run_k == KIND_ALPHA) ? PH_PAY : PH_IDX;
                end
              end
            end
          end
          PH_PAY: begin
            do_emit      = 1'b1;
            emit_kind    = run_kind_r;
            emit_n       = 8'd1;
            emit_a       = in_byte;
            run_left_nxt = run_left_r - 8'd1;
            if (run_left_nxt == 8'd0) begin
              phase_nxt = PH_OP;
            end
          end
          PH_IDX: begin
            held_index_nxt = in_byte;
            phase_nxt      = PH_PAIR;
          end
          PH_PAIR: begin
            do_emit      = 1'b1;
            emit_kind    = KIND_IDXA;
            emit_n       = 8'd1;
            emit_a       = held_index_r;
            emit_b       = in_byte;
            run_left_nxt = run_left_r - 8'd1;
            phase_nxt    = (run_left_nxt == 8'd0) ? PH_OP : PH_IDX;
          end
          PH_DRAIN: begin
          end
          PH_HDR0, PH_HDR1: begin
          end
          default: begin
          end
        endcase

        if (do_stop) begin
          saved_term_nxt = stop_code;
          phase_nxt      = PH_DRAIN;
        end
        if (do_emit) begin
          column_nxt = column_r + {8'd0, emit_n};
        end

        if (bl_dec == 15'd0) begin
          end_row = 1'b1;
          if (phase_nxt == PH_DRAIN) begin
            if (saved_term_nxt == TERM_BAD) begin
              bad = 1'b1;
            end else begin
              term = saved_term_nxt;
            end
          end else if (phase_nxt != PH_OP) begin
            bad = 1'b1;
          end
          phase_nxt = PH_HDR0;
        end
      end
    end
  end

  always_comb begin
    res_valid   = do_emit | end_row;
    res.kind    = emit_kind;
    res.x       = do_emit ? column_r : column_nxt;
    res.count   = emit_n;
    res.val_a   = emit_a;
    res.val_b   = emit_b;
    res.row_end = end_row;
    res.term    = end_row ? term : TERM_NONE;
    res.length  = end_row ? row_len_nxt : 15'd0;
    res.bad     = end_row & bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= 16'd0;
      phase_r       <= PH_HDR0;
      bytes_left_r  <= 15'd0;
      column_r      <= 16'd0;
      run_kind_r    <= KIND_SKIP;
      run_left_r    <= 8'd0;
      tint_r        <= 2'd0;
      held_index_r  <= 8'd0;
      header_high_r <= 7'd0;
      saved_term_r  <= TERM_NONE;
      row_len_r     <= 15'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        row_width_r <= cfg_data;
      end
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      column_r      <= column_nxt;
      run_kind_r    <= run_kind_nxt;
      run_left_r    <= run_left_nxt;
      tint_r        <= tint_nxt;
      held_index_r  <= held_index_nxt;
      header_high_r <= header_high_nxt;
      saved_term_r  <= saved_term_nxt;
      row_len_r     <= row_len_nxt;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_free) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_free) begin
        out_r <= skid_r;
      end
    end else if (out_free) begin
      out_r <= res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_kind  = out_r.kind;
  assign out_span_x     = out_r.x;
  assign out_span_count = out_r.count;
  assign out_value_a    = out_r.val_a;
  assign out_value_b    = out_r.val_b;
  assign out_row_end    = out_r.row_end;
  assign out_row_term   = out_r.term;
  assign out_row_length = out_r.length;
  assign out_malformed  = out_r.bad;

endmodule
`default_nettype wire
